@@ design/itavg_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itavg_pkg
// Shared types, widths and codes for the interval timer averager.
// ----------------------------------------------------------------------------
package itavg_pkg;

   // field widths
   localparam int STAMP_BITS = 48;
   localparam int CMD_W      = 3;
   localparam int TS_W       = 48;
   localparam int TAG_W      = 16;
   localparam int CNT_W      = 16;
   localparam int SUM_W      = 64;
   localparam int AVG_W      = 48;

   // stream packing
   localparam int REQ_BITS   = CMD_W + TS_W + TAG_W;
   localparam int REQ_DATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_W = AVG_W + SUM_W + TAG_W;
   localparam int RSP_USER_W = 2;

   // divider: one quotient bit per cycle
   localparam int DIV_STEPS = SUM_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam logic [AVG_W-1:0] AVG_MAX = '1;

   // command codes
   localparam logic [CMD_W-1:0] CMD_INIT  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_RESET = 3'd1;
   localparam logic [CMD_W-1:0] CMD_START = 3'd2;
   localparam logic [CMD_W-1:0] CMD_STOP  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_FINAL = 3'd4;

   // measurement phase
   typedef enum logic [2:0] {
      PH_CREATED     = 3'd0,
      PH_INITIALIZED = 3'd1,
      PH_TRACKING    = 3'd2,
      PH_MEASURED    = 3'd3,
      PH_FINALIZED   = 3'd4
   } phase_type;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_EXEC   = 2'd1,
      ST_DIVIDE = 2'd2,
      ST_PUSH   = 2'd3
   } ctrl_state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic exec;
      logic div_step;
      logic push;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic group_done;
      logic div_last;
      logic out_free;
   } dp_status_type;

   // mask that keeps the low STAMP_BITS of a time reading
   function automatic logic [TS_W-1:0] stamp_mask();
      logic [TS_W-1:0] m;
      m = '1;
      if (STAMP_BITS < TS_W) begin
         m = m >> (TS_W - STAMP_BITS);
      end
      return m;
   endfunction

endpackage
`default_nettype wire

@@ design/interval_timer_averager.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// interval_timer_averager
// Command-driven interval timer that averages groups of measured intervals.
// ----------------------------------------------------------------------------
// Every command transfer yields exactly one response. A command passes through
// capture, execute and load of the output register; a finalize that closes a
// group also runs, between execute and load, the radix-2 divider that forms
// the average by resolving one of the 64 quotient bits per cycle. The response
// sits in an output register, so the next command is taken and executed while
// the previous response waits; it stalls only when it needs that register.
// measure_count may be written at any time the block is idle and takes
// effect at the next init, reset or group completion.
module interval_timer_averager (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // tdata: command[2:0], timestamp[50:3], tag[66:51], zero pad[71:67]
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [itavg_pkg::REQ_DATA_W-1:0]  req_tdata,
   // tdata: average[47:0], total[111:48], tag_out[127:112]
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [itavg_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   // tuser: status[0], average_valid[1]
   output logic [itavg_pkg::RSP_USER_W-1:0]       rsp_tuser,
   // measure_count
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [itavg_pkg::CNT_W-1:0]       csr_data
);
   import itavg_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   // sequencer
   itavg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath
   itavg_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_tdata),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_data  (rsp_tdata),
      .rsp_user  (rsp_tuser)
   );

endmodule
`default_nettype wire

@@ design/itavg_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itavg_ctrl
// Sequencer: take a command, execute it, run the divider when a group
// completes, then hand the result to the output register.
// ----------------------------------------------------------------------------
module itavg_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire itavg_pkg::dp_status_type status,
   output itavg_pkg::ctrl_cmd_type      cmd
);
   import itavg_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = status.group_done ? ST_DIVIDE : ST_PUSH;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (status.out_free) begin
               cmd.push = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

@@ design/itavg_dpath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itavg_dpath
// Phase tracking, interval and sum registers, radix-2 divider and the
// output register of the result stream.
// ----------------------------------------------------------------------------
module itavg_dpath (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire itavg_pkg::ctrl_cmd_type           cmd,
   output itavg_pkg::dp_status_type               status,
   input  wire logic [itavg_pkg::REQ_DATA_W-1:0]  req_data,
   input  wire logic                              csr_valid,
   input  wire logic [itavg_pkg::CNT_W-1:0]       csr_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [itavg_pkg::RSP_DATA_W-1:0]       rsp_data,
   output logic [itavg_pkg::RSP_USER_W-1:0]       rsp_user
);
   import itavg_pkg::*;

   // captured command
   logic [CMD_W-1:0]      cmd_ff;
   logic [TS_W-1:0]       ts_ff;
   logic [TAG_W-1:0]      tag_ff;

   // measurement state
   phase_type             phase_ff, phase_in;
   logic [TS_W-1:0]       start_ff, start_in;
   logic [TS_W-1:0]       interval_ff, interval_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [CNT_W-1:0]      repeats_ff, repeats_in;
   logic [CNT_W-1:0]      mcount_ff;

   // pending result
   logic                  reject_ff, reject_in;
   logic [SUM_W-1:0]      total_ff;
   logic                  done_ff;

   // divider
   logic [SUM_W-1:0]      quot_ff;
   logic [CNT_W-1:0]      rem_ff;
   logic [CNT_W-1:0]      divisor_ff;
   logic [DIV_CNT_W-1:0]  div_cnt_ff;
   logic [CNT_W:0]        rem_shift;
   logic [CNT_W:0]        rem_diff;

   // output register
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_USER_W-1:0] rsp_user_ff;

   logic [SUM_W:0]        sum_wide;
   logic [SUM_W-1:0]      sum_sat;
   logic                  group_done;
   logic [AVG_W-1:0]      avg;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         mcount_ff <= CNT_W'(1);
      end else if (csr_valid) begin
         mcount_ff <= csr_data;
      end
   end

   // take the command fields on each transfer
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff <= req_data[CMD_W-1:0];
         ts_ff  <= req_data[CMD_W +: TS_W] & stamp_mask();
         tag_ff <= req_data[CMD_W+TS_W +: TAG_W];
      end
   end

   // saturating sum with the last interval
   assign sum_wide = {1'b0, sum_ff} + {{(SUM_W-TS_W+1){1'b0}}, interval_ff};
   assign sum_sat  = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];

   assign group_done = (cmd_ff == CMD_FINAL) && (phase_ff == PH_MEASURED) &&
                       (repeats_ff <= CNT_W'(1));

   // phase sequencer rules
   always_comb begin
      phase_in    = phase_ff;
      start_in    = start_ff;
      interval_in = interval_ff;
      sum_in      = sum_ff;
      repeats_in  = repeats_ff;
      reject_in   = 1'b1;
      case (cmd_ff)
         CMD_INIT: begin
            if (phase_ff == PH_CREATED) begin
               repeats_in = mcount_ff;
               phase_in   = PH_INITIALIZED;
               reject_in  = 1'b0;
            end
         end
         CMD_RESET: begin
            if (phase_ff == PH_INITIALIZED || phase_ff == PH_FINALIZED) begin
               repeats_in = mcount_ff;
               phase_in   = PH_INITIALIZED;
               reject_in  = 1'b0;
            end
         end
         CMD_START: begin
            if (phase_ff == PH_INITIALIZED || phase_ff == PH_FINALIZED) begin
               start_in  = ts_ff;
               phase_in  = PH_TRACKING;
               reject_in = 1'b0;
            end
         end
         CMD_STOP: begin
            if (phase_ff == PH_TRACKING) begin
               interval_in = (ts_ff - start_ff) & stamp_mask();
               phase_in    = PH_MEASURED;
               reject_in   = 1'b0;
            end
         end
         CMD_FINAL: begin
            if (phase_ff == PH_MEASURED) begin
               if (group_done) begin
                  sum_in     = '0;
                  repeats_in = mcount_ff;
               end else begin
                  sum_in     = sum_sat;
                  repeats_in = repeats_ff - CNT_W'(1);
               end
               phase_in  = PH_FINALIZED;
               reject_in = 1'b0;
            end
         end
         default: begin
            reject_in = 1'b1;
         end
      endcase
   end

   // measurement state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_CREATED;
         start_ff    <= '0;
         interval_ff <= '0;
         sum_ff      <= '0;
         repeats_ff  <= CNT_W'(1);
      end else if (cmd.exec) begin
         phase_ff    <= phase_in;
         start_ff    <= start_in;
         interval_ff <= interval_in;
         sum_ff      <= sum_in;
         repeats_ff  <= repeats_in;
      end
   end

   // divider step: shift one dividend bit into the remainder
   assign rem_shift = {rem_ff, quot_ff[SUM_W-1]};
   assign rem_diff  = rem_shift - {1'b0, divisor_ff};

   // result and divider registers
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         reject_ff  <= reject_in;
         done_ff    <= group_done;
         total_ff   <= group_done ? sum_sat : '0;
         quot_ff    <= group_done ? sum_sat : '0;
         rem_ff     <= '0;
         divisor_ff <= (mcount_ff == '0) ? CNT_W'(1) : mcount_ff;
      end else if (cmd.div_step) begin
         if (!rem_diff[CNT_W]) begin
            rem_ff  <= rem_diff[CNT_W-1:0];
            quot_ff <= {quot_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_ff  <= rem_shift[CNT_W-1:0];
            quot_ff <= {quot_ff[SUM_W-2:0], 1'b0};
         end
      end
   end

   // divider step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff <= '0;
      end else if (cmd.exec) begin
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         div_cnt_ff <= div_cnt_ff + DIV_CNT_W'(1);
      end
   end

   // clamp the quotient to the average width
   assign avg = (|quot_ff[SUM_W-1:AVG_W]) ? AVG_MAX : quot_ff[AVG_W-1:0];

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.push) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         rsp_data_ff <= {tag_ff, total_ff, avg};
         rsp_user_ff <= {done_ff, reject_ff};
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign rsp_user  = rsp_user_ff;

   assign status.group_done = group_done;
   assign status.div_last   = (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1));
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

endmodule
`default_nettype wire

@@ design/itavg_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itavg_checker
// Port-level checks of the response stream of the interval timer averager.
// ----------------------------------------------------------------------------
module itavg_checker (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   input  wire logic [itavg_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  wire logic [itavg_pkg::RSP_USER_W-1:0]  rsp_tuser
);
   import itavg_pkg::*;

   logic [AVG_W-1:0] avg;
   logic [SUM_W-1:0] total;

   assign avg   = rsp_tdata[AVG_W-1:0];
   assign total = rsp_tdata[AVG_W +: SUM_W];

   // a completed group is always an accepted command
   a_done_not_rejected: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> !rsp_tuser[0])
      else $error("average reported on a rejected command");

   // without a completed group average and total read zero
   a_idle_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[1] |-> (avg == '0) && (total == '0))
      else $error("average or total nonzero without a completed group");

   // divisor is at least one, so the mean never exceeds the sum
   a_avg_le_total: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> ({{(SUM_W-AVG_W){1'b0}}, avg} <= total))
      else $error("average above total");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

endmodule

bind interval_timer_averager itavg_checker u_itavg_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire

@@ dv/interval_timer_averager_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_timer_averager_test
// Self-checking bench for the interval timer averager. Directed tests send
// commands in every measurement phase, cover the measure_count corners
// and the average saturation case. Random traffic then runs start/stop/finalize
// sequences mixed with stray and unknown commands. A scoreboard predicts each
// response and compares it field by field against the rsp stream.
// ----------------------------------------------------------------------------
module interval_timer_averager_test;
   import itavg_pkg::*;

   localparam int LIMIT_CYCLES = 6000000;
   localparam int TAIL_CYCLES  = 100;
   localparam logic STATUS_OK     = 1'b0;
   localparam logic STATUS_DENIED = 1'b1;
   localparam logic [CMD_W-1:0] CMD_TOP_CODE = '1;
   localparam logic [TS_W-1:0]  STAMP_MASK   = {TS_W{1'b1}} >> (TS_W - STAMP_BITS);
   localparam logic [TS_W-1:0]  STAMP_MAX    = STAMP_MASK;
   localparam logic [SUM_W-1:0] SUM_MAX      = '1;
   localparam logic [CNT_W-1:0] COUNT_MAX    = '1;
   localparam logic [TAG_W-1:0] TAG_MAX      = '1;

   // one response as the block reports it
   typedef struct packed {
      logic             status;
      logic             avg_valid;
      logic [AVG_W-1:0] average;
      logic [SUM_W-1:0] total;
      logic [TAG_W-1:0] tag;
   } meas_result_t;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CNT_W-1:0]      csr_data   = '0;

   // tracker state as the scoreboard sees it
   phase_type        trk_phase;
   logic [TS_W-1:0]  trk_start;
   logic [TS_W-1:0]  trk_interval;
   logic [SUM_W-1:0] trk_sum;
   logic [CNT_W-1:0] trk_left;
   logic [CNT_W-1:0] trk_count;

   meas_result_t pending_results[$];

   bit sender_gaps_on = 1'b1;
   bit rsp_stalls_on  = 1'b1;
   int stall_left     = 0;
   int fail_count     = 0;
   int items_sent     = 0;
   int results_seen   = 0;
   int groups_seen    = 0;
   int denied_seen    = 0;
   int csr_writes     = 0;
   int cycle_count    = 0;

   always #6 clock = ~clock;

   interval_timer_averager i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // idle length: mostly none or short, now and then long
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   // random measurement number
   function automatic logic [TAG_W-1:0] random_tag();
      return TAG_W'($urandom);
   endfunction

   // time reading with extra weight on the ends of the range
   function automatic logic [TS_W-1:0] random_stamp();
      logic [TS_W-1:0] stamp;
      stamp = TS_W'({$urandom, $urandom});
      case ($urandom_range(0, 9))
         0: stamp = '0;
         1: stamp = STAMP_MAX;
         default: ;
      endcase
      return stamp;
   endfunction

   // stop reading some distance after origin, wrapping past the top at times
   function automatic logic [TS_W-1:0] later_stamp(input logic [TS_W-1:0] origin);
      logic [TS_W-1:0] delta;
      case ($urandom_range(0, 3))
         0: delta = TS_W'($urandom_range(0, 1000));
         1: delta = TS_W'($urandom);
         default: delta = TS_W'({$urandom, $urandom});
      endcase
      return origin + delta;
   endfunction

   // advance the tracker by one command and return the response it owes
   function automatic meas_result_t predict_measurement(input logic [CMD_W-1:0] cmd,
                                                        input logic [TS_W-1:0]  stamp,
                                                        input logic [TAG_W-1:0] tag);
      meas_result_t     r;
      logic [SUM_W:0]   wide_sum;
      logic [SUM_W-1:0] divisor;
      logic [SUM_W-1:0] quotient;
      r        = '0;
      r.status = STATUS_DENIED;
      r.tag    = tag;
      case (cmd)
         CMD_INIT: begin
            if (trk_phase == PH_CREATED) begin
               trk_left  = trk_count;
               trk_phase = PH_INITIALIZED;
               r.status  = STATUS_OK;
            end
         end
         CMD_RESET: begin
            if (trk_phase == PH_INITIALIZED || trk_phase == PH_FINALIZED) begin
               trk_left  = trk_count;
               trk_phase = PH_INITIALIZED;
               r.status  = STATUS_OK;
            end
         end
         CMD_START: begin
            if (trk_phase == PH_INITIALIZED || trk_phase == PH_FINALIZED) begin
               trk_start = stamp & STAMP_MASK;
               trk_phase = PH_TRACKING;
               r.status  = STATUS_OK;
            end
         end
         CMD_STOP: begin
            if (trk_phase == PH_TRACKING) begin
               trk_interval = (stamp - trk_start) & STAMP_MASK;
               trk_phase    = PH_MEASURED;
               r.status     = STATUS_OK;
            end
         end
         CMD_FINAL: begin
            if (trk_phase == PH_MEASURED) begin
               wide_sum = {1'b0, trk_sum} + {{(SUM_W-TS_W+1){1'b0}}, trk_interval};
               trk_sum  = wide_sum[SUM_W] ? SUM_MAX : wide_sum[SUM_W-1:0];
               // a counter of zero closes the group just like one
               if (trk_left <= CNT_W'(1)) begin
                  divisor     = (trk_count == '0) ? SUM_W'(1) : SUM_W'(trk_count);
                  quotient    = trk_sum / divisor;
                  r.average   = (quotient > SUM_W'(AVG_MAX)) ? AVG_MAX : quotient[AVG_W-1:0];
                  r.total     = trk_sum;
                  r.avg_valid = 1'b1;
                  trk_sum     = '0;
                  trk_left    = trk_count;
               end else begin
                  trk_left = trk_left - CNT_W'(1);
               end
               trk_phase = PH_FINALIZED;
               r.status  = STATUS_OK;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // one command transfer; tvalid stays high for a back-to-back follower
   task automatic issue_command(input logic [CMD_W-1:0] cmd,
                                input logic [TS_W-1:0]  stamp,
                                input logic [TAG_W-1:0] tag);
      int gap;
      gap = sender_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W - REQ_BITS){1'b0}}, tag, stamp, cmd};
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(predict_measurement(cmd, stamp, tag));
      items_sent++;
   endtask

   // start, stop and finalize of one measurement
   task automatic run_interval(input logic [TS_W-1:0] t_start, input logic [TS_W-1:0] t_stop,
                               input logic [TAG_W-1:0] tag);
      issue_command(CMD_START, t_start, tag);
      issue_command(CMD_STOP, t_stop, tag);
      issue_command(CMD_FINAL, random_stamp(), tag);
   endtask

   // hold off the sender until every response is back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // measure_count write, only with the block idle
   task automatic set_measure_count(input logic [CNT_W-1:0] value);
      drain_results();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      trk_count = value;
      csr_writes++;
   endtask

   // every command except init is refused before init, unknown codes always
   task automatic test_before_init();
      logic [CMD_W-1:0] bad_cmd;
      issue_command(CMD_STOP, STAMP_MAX, '0);
      issue_command(CMD_FINAL, '0, TAG_MAX);
      issue_command(CMD_RESET, random_stamp(), random_tag());
      issue_command(CMD_START, STAMP_MAX, random_tag());
      for (int code = int'(CMD_FINAL) + 1; code <= int'(CMD_TOP_CODE); code++) begin
         bad_cmd = CMD_W'(code);
         issue_command(bad_cmd, random_stamp(), random_tag());
      end
      issue_command(CMD_INIT, '0, 16'h5a5a);
      issue_command(CMD_INIT, STAMP_MAX, 16'ha5a5);
   endtask

   // widest and wrapped intervals, and refusals in the tracking, measured and finalized phases
   task automatic test_single_intervals();
      run_interval('0, STAMP_MAX, '0);
      run_interval(STAMP_MAX, '0, TAG_MAX);
      issue_command(CMD_STOP, random_stamp(), random_tag());
      issue_command(CMD_FINAL, random_stamp(), random_tag());
      issue_command(CMD_START, 48'h0000_1234_5678, random_tag());
      issue_command(CMD_START, random_stamp(), random_tag());
      issue_command(CMD_RESET, random_stamp(), random_tag());
      issue_command(CMD_STOP, 48'h0000_1234_5678, random_tag());
      issue_command(CMD_RESET, random_stamp(), random_tag());
      issue_command(CMD_STOP, random_stamp(), random_tag());
      issue_command(CMD_FINAL, random_stamp(), random_tag());
      issue_command(CMD_INIT, random_stamp(), random_tag());
   endtask

   // zero count, sum kept over reset, and a write in the middle of a group
   task automatic test_count_corners();
      set_measure_count('0);
      issue_command(CMD_RESET, '0, random_tag());
      run_interval(48'd100, 48'd350, random_tag());
      run_interval(random_stamp(), random_stamp(), random_tag());
      set_measure_count(16'd3);
      issue_command(CMD_RESET, '0, random_tag());
      run_interval(48'd0, 48'd10, random_tag());
      run_interval(48'd5, 48'd16, random_tag());
      run_interval(48'd7, 48'd19, random_tag());
      set_measure_count(COUNT_MAX);
      issue_command(CMD_RESET, '0, random_tag());
      run_interval(random_stamp(), random_stamp(), random_tag());
      run_interval(random_stamp(), random_stamp(), random_tag());
      set_measure_count(16'd2);
      issue_command(CMD_RESET, '0, random_tag());
      run_interval(random_stamp(), random_stamp(), random_tag());
      run_interval(random_stamp(), random_stamp(), random_tag());
      set_measure_count(16'd4);
      issue_command(CMD_RESET, '0, random_tag());
      run_interval(random_stamp(), random_stamp(), random_tag());
      run_interval(random_stamp(), random_stamp(), random_tag());
      // new count only divides here, counter keeps its old load
      set_measure_count(16'd3);
      run_interval(random_stamp(), random_stamp(), random_tag());
      run_interval(random_stamp(), random_stamp(), random_tag());
      run_interval(random_stamp(), random_stamp(), random_tag());
   endtask

   // sum carried over resets, then divided by one, overflows the average
   task automatic test_average_saturation();
      set_measure_count(16'd2);
      issue_command(CMD_RESET, '0, random_tag());
      repeat (4) begin
         run_interval('0, STAMP_MAX, random_tag());
         issue_command(CMD_RESET, '0, random_tag());
      end
      set_measure_count(16'd1);
      issue_command(CMD_RESET, '0, random_tag());
      run_interval('0, STAMP_MAX, random_tag());
   endtask

   // mostly well-formed measurements with random content, plus noise
   task automatic random_phase(input int items, input logic [CNT_W-1:0] count);
      int               first_item;
      int               roll;
      bit               drained;
      logic [TS_W-1:0]  t0;
      logic [CMD_W-1:0] any_cmd;
      set_measure_count(count);
      first_item = items_sent;
      drained    = 1'b0;
      while (items_sent - first_item < items) begin
         roll = $urandom_range(0, 99);
         if (roll < 78) begin
            t0 = random_stamp();
            run_interval(t0, later_stamp(t0), random_tag());
         end else if (roll < 86) begin
            issue_command(CMD_RESET, random_stamp(), random_tag());
         end else if (roll < 95) begin
            any_cmd = CMD_W'($urandom_range(int'(CMD_INIT), int'(CMD_FINAL)));
            issue_command(any_cmd, random_stamp(), random_tag());
         end else begin
            any_cmd = CMD_W'($urandom_range(int'(CMD_FINAL) + 1, int'(CMD_TOP_CODE)));
            issue_command(any_cmd, random_stamp(), random_tag());
         end
         if (!drained && items_sent - first_item >= items / 2) begin
            drain_results();
            drained = 1'b1;
         end
      end
   endtask

   task automatic test_random_traffic();
      random_phase(200, 16'd1);
      random_phase(200, CNT_W'($urandom_range(2, 4)));
      sender_gaps_on = 1'b0;
      rsp_stalls_on  = 1'b0;
      random_phase(150, CNT_W'($urandom_range(2, 6)));
      sender_gaps_on = 1'b1;
      rsp_stalls_on  = 1'b1;
      random_phase(150, COUNT_MAX);
      random_phase(200, CNT_W'($urandom_range(1, 12)));
      random_phase(200, 16'd3);
   endtask

   task automatic report_field(input string field, input logic [SUM_W-1:0] expected,
                               input logic [SUM_W-1:0] actual);
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, expected, actual);
      fail_count++;
   endtask

   // response check and rsp_tready stalls
   always @(posedge clock) begin
      meas_result_t want;
      meas_result_t got;
      int           gap;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         got.status    = rsp_tuser[0];
         got.avg_valid = rsp_tuser[1];
         got.average   = rsp_tdata[AVG_W-1:0];
         got.total     = rsp_tdata[AVG_W +: SUM_W];
         got.tag       = rsp_tdata[AVG_W + SUM_W +: TAG_W];
         if (got.status == STATUS_DENIED) denied_seen++;
         if (got.avg_valid) groups_seen++;
         if (pending_results.size() == 0) begin
            $display("%0t: response with nothing outstanding, tuser %h tdata %h",
                     $time, rsp_tuser, rsp_tdata);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            if (got.status != want.status)
               report_field("status", SUM_W'(want.status), SUM_W'(got.status));
            if (got.avg_valid != want.avg_valid)
               report_field("average_valid", SUM_W'(want.avg_valid), SUM_W'(got.avg_valid));
            if (got.average != want.average)
               report_field("average", SUM_W'(want.average), SUM_W'(got.average));
            if (got.total != want.total) report_field("total", want.total, got.total);
            if (got.tag != want.tag)
               report_field("tag_out", SUM_W'(want.tag), SUM_W'(got.tag));
         end
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (!rsp_stalls_on) begin
         rsp_tready <= 1'b1;
      end else begin
         gap = pick_gap();
         stall_left = (gap > 0) ? gap - 1 : 0;
         rsp_tready <= (gap == 0);
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("%0t: run limit reached, %0d responses outstanding",
                  $time, pending_results.size());
         $display("interval_timer_averager verification failed");
         $finish;
      end
   end

   initial begin
      trk_phase    = PH_CREATED;
      trk_start    = '0;
      trk_interval = '0;
      trk_sum      = '0;
      trk_left     = 16'd1;
      trk_count    = 16'd1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_before_init();
      test_single_intervals();
      test_count_corners();
      test_average_saturation();
      test_random_traffic();
      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_results.size() != 0) begin
         $display("%0t: %0d responses never arrived", $time, pending_results.size());
         fail_count++;
      end
      $display("covered %0d commands, %0d refused, %0d group averages, %0d count writes",
               items_sent, denied_seen, groups_seen, csr_writes);
      $display("including a saturated average, zero count and mid-group writes");
      if (fail_count == 0) begin
         $display("interval_timer_averager verification clean");
      end else begin
         $display("interval_timer_averager verification failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
design/itavg_pkg.sv
design/itavg_ctrl.sv
design/itavg_dpath.sv
design/interval_timer_averager.sv
design/itavg_checker.sv
dv/interval_timer_averager_test.sv
